[rtl/ecfr_pkg.sv]
package ecfr_pkg;

   // Default sizes
   localparam int MAX_PAYLOAD_DEFAULT  = 256;
   localparam int RAW_DEPTH_DEFAULT    = 512;
   localparam int DECODE_DEPTH_DEFAULT = 512;

   // Frame layout
   localparam int HDR_LEN   = 9;
   localparam int CRC_LEN   = 4;
   localparam int MIN_FRAME = HDR_LEN + CRC_LEN;

   // CRC-32, reflected
   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

   // COBS code for a full block without a trailing zero
   localparam logic [7:0] COBS_LONG = 8'hFF;

   // Register indexes
   localparam logic [1:0] CSR_MARKER = 2'd0;
   localparam logic [1:0] CSR_ESCAPE = 2'd1;
   localparam logic [1:0] CSR_XOR    = 2'd2;

   localparam logic [7:0] MARKER_RESET = 8'd126;
   localparam logic [7:0] ESCAPE_RESET = 8'd125;
   localparam logic [7:0] XOR_RESET    = 8'd32;

   // Request functions and result kinds
   localparam logic FUNC_PUSH   = 1'b0;
   localparam logic FUNC_READ   = 1'b1;
   localparam logic KIND_REPORT = 1'b0;
   localparam logic KIND_READ   = 1'b1;

   // Report status codes
   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_COBS   = 3'd1;
   localparam logic [2:0] ST_SHORT  = 3'd2;
   localparam logic [2:0] ST_LENGTH = 3'd3;
   localparam logic [2:0] ST_CRC    = 3'd4;

   typedef struct packed {
      logic       func;
      logic [7:0] wire_byte;
      logic [7:0] read_index;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [2:0]  status;
      logic [7:0]  frame_type;
      logic [7:0]  xfer_id;
      logic [7:0]  frame_flags;
      logic [31:0] sequence_res;
      logic [8:0]  payload_length;
      logic [7:0]  read_data;
   } rsp_type;

   typedef struct packed {
      logic frame_open;
      logic store;
      logic store_xor;
      logic drop;
      logic dec_start;
      logic raw_rd;
      logic dec_use;
      logic dec_zero;
      logic report;
      logic read_issue;
      logic read_load;
   } cmd_type;

   typedef struct packed {
      logic func;
      logic is_marker;
      logic is_escape;
      logic raw_empty;
      logic raw_full;
      logic dec_done;
      logic use_err;
      logic use_zero;
      logic zero_err;
      logic out_free;
   } sts_type;

   // Advance the CRC by one byte, LSB first
   function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int b = 0; b < 8; b++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

[rtl/escaped_cobs_crc_frame_receiver.sv]
// Wire byte request: a plain byte leaves the accept state in place, so the next request may follow at once.
// Closing marker of a non-empty frame: the walk over the raw store through its read port reads and uses
// each stored byte, inserts each zero in a step of its own, then reports; no request is taken meanwhile.
// Read request: the result is registered once the output register is free; no request is taken meanwhile.
// Synchronous active-high reset clears mode, the raw byte count, last length, output valid
// and restores register defaults; both byte stores keep their contents.
module escaped_cobs_crc_frame_receiver #(
   parameter int MAX_PAYLOAD  = ecfr_pkg::MAX_PAYLOAD_DEFAULT,
   parameter int RAW_DEPTH    = ecfr_pkg::RAW_DEPTH_DEFAULT,
   parameter int DECODE_DEPTH = ecfr_pkg::DECODE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ecfr_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ecfr_pkg::rsp_type rsp_payload,
   input  logic              csr_write_enable,
   input  logic [1:0]        csr_index,
   input  logic [7:0]        csr_write_data
);
   import ecfr_pkg::*;

   cmd_type cmd;
   sts_type sts;

   ecfr_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .sts      (sts),
      .cmd      (cmd)
   );

   ecfr_datapath #(
      .MAX_PAYLOAD (MAX_PAYLOAD),
      .RAW_DEPTH   (RAW_DEPTH),
      .DECODE_DEPTH(DECODE_DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_payload     (req_payload),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_payload     (rsp_payload)
   );

endmodule

[rtl/ecfr_ram.sv]
module ecfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/ecfr_ctrl.sv]
module ecfr_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ecfr_pkg::sts_type sts,
   output ecfr_pkg::cmd_type cmd
);
   import ecfr_pkg::*;

   localparam logic [2:0] S_ACCEPT   = 3'd0;
   localparam logic [2:0] S_RAW_RD   = 3'd1;
   localparam logic [2:0] S_RAW_USE  = 3'd2;
   localparam logic [2:0] S_ZERO     = 3'd3;
   localparam logic [2:0] S_REPORT   = 3'd4;
   localparam logic [2:0] S_READ_OUT = 3'd5;

   localparam logic [1:0] MODE_IDLE  = 2'd0;
   localparam logic [1:0] MODE_FRAME = 2'd1;
   localparam logic [1:0] MODE_ESC   = 2'd2;

   logic [2:0] state_ff, state_in;
   logic [1:0] mode_ff, mode_in;

   assign req_ready = (state_ff == S_ACCEPT);

   // Sequence requests and the end-of-frame decode walk
   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      cmd      = '0;
      unique case (state_ff)
         S_ACCEPT: begin
            if (req_valid) begin
               if (sts.func == FUNC_READ) begin
                  cmd.read_issue = 1'b1;
                  state_in       = S_READ_OUT;
               end else begin
                  unique case (mode_ff)
                     MODE_IDLE: begin
                        if (sts.is_marker) begin
                           cmd.frame_open = 1'b1;
                           mode_in        = MODE_FRAME;
                        end
                     end
                     MODE_FRAME: begin
                        if (sts.is_marker) begin
                           if (!sts.raw_empty) begin
                              cmd.dec_start = 1'b1;
                              mode_in       = MODE_IDLE;
                              state_in      = S_RAW_RD;
                           end
                        end else if (sts.is_escape) begin
                           mode_in = MODE_ESC;
                        end else if (sts.raw_full) begin
                           cmd.drop = 1'b1;
                           mode_in  = MODE_IDLE;
                        end else begin
                           cmd.store = 1'b1;
                        end
                     end
                     MODE_ESC: begin
                        if (sts.raw_full) begin
                           cmd.drop = 1'b1;
                           mode_in  = MODE_IDLE;
                        end else begin
                           cmd.store     = 1'b1;
                           cmd.store_xor = 1'b1;
                           mode_in       = MODE_FRAME;
                        end
                     end
                     default: begin
                        mode_in = MODE_IDLE;
                     end
                  endcase
               end
            end
         end
         S_RAW_RD: begin
            if (sts.dec_done) begin
               state_in = S_REPORT;
            end else begin
               cmd.raw_rd = 1'b1;
               state_in   = S_RAW_USE;
            end
         end
         S_RAW_USE: begin
            cmd.dec_use = 1'b1;
            if (sts.use_err) begin
               state_in = S_REPORT;
            end else if (sts.use_zero) begin
               state_in = S_ZERO;
            end else begin
               state_in = S_RAW_RD;
            end
         end
         S_ZERO: begin
            cmd.dec_zero = 1'b1;
            state_in     = sts.zero_err ? S_REPORT : S_RAW_RD;
         end
         S_REPORT: begin
            if (sts.out_free) begin
               cmd.report = 1'b1;
               state_in   = S_ACCEPT;
            end
         end
         S_READ_OUT: begin
            if (sts.out_free) begin
               cmd.read_load = 1'b1;
               state_in      = S_ACCEPT;
            end
         end
         default: begin
            state_in = S_ACCEPT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_ACCEPT;
         mode_ff  <= MODE_IDLE;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
      end
   end

endmodule

[rtl/ecfr_datapath.sv]
module ecfr_datapath #(
   parameter int MAX_PAYLOAD  = ecfr_pkg::MAX_PAYLOAD_DEFAULT,
   parameter int RAW_DEPTH    = ecfr_pkg::RAW_DEPTH_DEFAULT,
   parameter int DECODE_DEPTH = ecfr_pkg::DECODE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  ecfr_pkg::req_type req_payload,
   input  logic              csr_write_enable,
   input  logic [1:0]        csr_index,
   input  logic [7:0]        csr_write_data,
   input  ecfr_pkg::cmd_type cmd,
   output ecfr_pkg::sts_type sts,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ecfr_pkg::rsp_type rsp_payload
);
   import ecfr_pkg::*;

   localparam int RCW    = $clog2(RAW_DEPTH + 1);
   localparam int RAW_AW = $clog2(RAW_DEPTH);
   localparam int DCW    = $clog2(DECODE_DEPTH + 1);
   localparam int DEC_AW = $clog2(DECODE_DEPTH);
   localparam int LLW    = $clog2(MAX_PAYLOAD + 1);
   localparam int SW     = ((RCW > DCW) ? RCW : DCW) + 18;

   // Configuration
   logic [7:0] marker_ff, escape_ff, xor_ff;

   // Receive and decode state
   logic [RCW-1:0] raw_count_ff, raw_count_in;
   logic [RCW-1:0] rd_ff, rd_in;
   logic [DCW-1:0] wr_ff, wr_in;
   logic [7:0]     left_ff, left_in;
   logic [7:0]     code_ff, code_in;
   logic           err_ff, err_in;
   logic [31:0]    crc_ff, crc_in;
   logic [31:0]    rxcrc_ff, rxcrc_in;
   logic [7:0]     hdr_ff [HDR_LEN];
   logic [7:0]     hdr_in [HDR_LEN];
   logic [LLW-1:0] last_len_ff, last_len_in;
   logic           hit_ff, hit_in;

   // Output register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic [7:0]        raw_q, dec_q;
   logic [7:0]        store_byte;
   logic              is_code, code_bad;
   logic [7:0]        copy, code_cur, left_next;
   logic [RCW-1:0]    rd_next;
   logic              emit;
   logic [7:0]        emit_byte;
   logic [15:0]       plen;
   logic [SW-1:0]     wr_ext, plen_ext, pos_ext;
   logic              wr_full;
   logic [2:0]        status;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         marker_ff <= MARKER_RESET;
         escape_ff <= ESCAPE_RESET;
         xor_ff    <= XOR_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MARKER: marker_ff <= csr_write_data;
            CSR_ESCAPE: escape_ff <= csr_write_data;
            CSR_XOR:    xor_ff    <= csr_write_data;
            default:    ;
         endcase
      end
   end

   assign store_byte = cmd.store_xor ? (req_payload.wire_byte ^ xor_ff) : req_payload.wire_byte;
   assign plen       = {hdr_ff[8], hdr_ff[7]};
   assign wr_ext     = SW'(wr_ff);
   assign plen_ext   = SW'(plen);
   assign pos_ext    = SW'(HDR_LEN) + SW'(req_payload.read_index);
   assign wr_full    = (wr_ff == DCW'(DECODE_DEPTH));

   // Classify the raw byte under decode
   assign is_code   = (left_ff == 8'd0);
   assign code_cur  = is_code ? raw_q : code_ff;
   assign copy      = raw_q - 8'd1;
   assign code_bad  = (raw_q == 8'd0)
                   || (SW'(rd_ff) + SW'(1) + SW'(copy) > SW'(raw_count_ff))
                   || (wr_ext + SW'(copy) > SW'(DECODE_DEPTH));
   assign left_next = is_code ? copy : (left_ff - 8'd1);
   assign rd_next   = rd_ff + RCW'(1);

   // Emit one decoded byte
   always_comb begin
      emit      = 1'b0;
      emit_byte = raw_q;
      if (cmd.dec_use && !is_code) begin
         emit = 1'b1;
      end else if (cmd.dec_zero && !wr_full) begin
         emit      = 1'b1;
         emit_byte = 8'd0;
      end
   end

   // Final status of a frame
   always_comb begin
      if (err_ff) begin
         status = ST_COBS;
      end else if (wr_ext < SW'(MIN_FRAME)) begin
         status = ST_SHORT;
      end else if (plen_ext > SW'(MAX_PAYLOAD) || wr_ext != SW'(MIN_FRAME) + plen_ext) begin
         status = ST_LENGTH;
      end else if ((crc_ff ^ CRC_INIT) != rxcrc_ff) begin
         status = ST_CRC;
      end else begin
         status = ST_OK;
      end
   end

   // Next state of the datapath
   always_comb begin
      raw_count_in = raw_count_ff;
      rd_in        = rd_ff;
      wr_in        = wr_ff;
      left_in      = left_ff;
      code_in      = code_ff;
      err_in       = err_ff;
      crc_in       = crc_ff;
      rxcrc_in     = rxcrc_ff;
      hdr_in       = hdr_ff;
      last_len_in  = last_len_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // Count stored raw bytes
      if (cmd.frame_open || cmd.drop || cmd.report) begin
         raw_count_in = '0;
      end else if (cmd.store) begin
         raw_count_in = raw_count_ff + RCW'(1);
      end

      if (cmd.dec_start) begin
         rd_in    = '0;
         wr_in    = '0;
         left_in  = '0;
         err_in   = 1'b0;
         crc_in   = CRC_INIT;
         rxcrc_in = '0;
      end

      // Advance the raw pointer
      if (cmd.dec_use) begin
         if (is_code && code_bad) begin
            err_in = 1'b1;
         end else begin
            rd_in   = rd_next;
            left_in = left_next;
            code_in = code_cur;
         end
      end
      if (cmd.dec_zero && wr_full) begin
         err_in = 1'b1;
      end

      // Capture header, run the CRC, collect the trailing check word
      if (emit) begin
         wr_in = wr_ff + DCW'(1);
         for (int i = 0; i < HDR_LEN; i++) begin
            if (wr_ff == DCW'(i)) begin
               hdr_in[i] = emit_byte;
            end
         end
         if (wr_ext < SW'(HDR_LEN) || wr_ext < SW'(HDR_LEN) + plen_ext) begin
            crc_in = crc32_byte(crc_ff, emit_byte);
         end else if (wr_ext < SW'(MIN_FRAME) + plen_ext) begin
            rxcrc_in = {emit_byte, rxcrc_ff[31:8]};
         end
      end

      if (cmd.read_issue) begin
         hit_in = (SW'(req_payload.read_index) < SW'(last_len_ff))
               && (pos_ext < SW'(DECODE_DEPTH));
      end

      // Load the output register
      if (cmd.report) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '0;
         rsp_in.kind   = KIND_REPORT;
         rsp_in.status = status;
         if (status == ST_OK) begin
            rsp_in.frame_type     = hdr_ff[0];
            rsp_in.xfer_id        = hdr_ff[1];
            rsp_in.frame_flags    = hdr_ff[2];
            rsp_in.sequence_res   = {hdr_ff[6], hdr_ff[5], hdr_ff[4], hdr_ff[3]};
            rsp_in.payload_length = plen[8:0];
            last_len_in           = LLW'(plen);
         end else begin
            last_len_in = '0;
         end
      end else if (cmd.read_load) begin
         rsp_valid_in     = 1'b1;
         rsp_in           = '0;
         rsp_in.kind      = KIND_READ;
         rsp_in.read_data = hit_ff ? dec_q : 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_count_ff <= '0;
         last_len_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         raw_count_ff <= raw_count_in;
         last_len_ff  <= last_len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff    <= rd_in;
      wr_ff    <= wr_in;
      left_ff  <= left_in;
      code_ff  <= code_in;
      err_ff   <= err_in;
      crc_ff   <= crc_in;
      rxcrc_ff <= rxcrc_in;
      hdr_ff   <= hdr_in;
      hit_ff   <= hit_in;
      rsp_ff   <= rsp_in;
   end

   // Raw byte store
   ecfr_ram #(
      .WIDTH(8),
      .DEPTH(RAW_DEPTH)
   ) u_raw_ram (
      .clock  (clock),
      .wr_en  (cmd.store),
      .wr_addr(raw_count_ff[RAW_AW-1:0]),
      .wr_data(store_byte),
      .rd_en  (cmd.raw_rd),
      .rd_addr(rd_ff[RAW_AW-1:0]),
      .rd_data(raw_q)
   );

   // Decoded frame store
   ecfr_ram #(
      .WIDTH(8),
      .DEPTH(DECODE_DEPTH)
   ) u_dec_ram (
      .clock  (clock),
      .wr_en  (emit),
      .wr_addr(wr_ff[DEC_AW-1:0]),
      .wr_data(emit_byte),
      .rd_en  (cmd.read_issue),
      .rd_addr(pos_ext[DEC_AW-1:0]),
      .rd_data(dec_q)
   );

   // Status toward the controller
   always_comb begin
      sts           = '0;
      sts.func      = req_payload.func;
      sts.is_marker = (req_payload.wire_byte == marker_ff);
      sts.is_escape = (req_payload.wire_byte == escape_ff);
      sts.raw_empty = (raw_count_ff == '0);
      sts.raw_full  = (raw_count_ff == RCW'(RAW_DEPTH));
      sts.dec_done  = (rd_ff == raw_count_ff);
      sts.use_err   = is_code && code_bad;
      sts.use_zero  = !(is_code && code_bad) && (left_next == 8'd0)
                   && (code_cur < COBS_LONG) && (rd_next < raw_count_ff);
      sts.zero_err  = wr_full;
      sts.out_free  = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      raw_count_ff <= RCW'(RAW_DEPTH))
      else $error("raw count beyond store depth");
   assert property (@(posedge clock) disable iff (reset)
      cmd.dec_use |-> rd_ff < raw_count_ff)
      else $error("decode read past stored bytes");
   assert property (@(posedge clock) disable iff (reset)
      emit |-> wr_ff < DCW'(DECODE_DEPTH))
      else $error("decoded write beyond store depth");
   assert property (@(posedge clock) disable iff (reset)
      (cmd.report || cmd.read_load) |=> rsp_valid_ff)
      else $error("loaded result not presented");
`endif

endmodule

[bench/escaped_cobs_crc_frame_receiver_test.sv]
`timescale 1ns / 100ps

module escaped_cobs_crc_frame_receiver_test;
   import ecfr_pkg::*;

   localparam int PAYLOAD_LIMIT = 256;
   localparam int RAW_SIZE      = 512;
   localparam int DEC_SIZE      = 512;
   localparam int SETTLE_CYCLES = 1400;

   typedef enum logic [1:0] {RX_IDLE, RX_FRAME, RX_ESC} rx_mode_type;

   // Frame damage applied by the frame builder
   typedef enum int {
      DMG_NONE, DMG_CRC, DMG_LEN_FIELD, DMG_TRUNC, DMG_ZERO_CODE, DMG_OVERRUN
   } damage_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_payload;
   logic       csr_write_enable;
   logic [1:0] csr_index;
   logic [7:0] csr_write_data;

   escaped_cobs_crc_frame_receiver dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   // Predictor state
   logic [7:0]  cfg_marker, cfg_escape, cfg_xor;
   rx_mode_type rx_mode;
   logic [7:0]  raw_bytes [RAW_SIZE];
   int          raw_fill;
   logic [7:0]  frame_bytes [DEC_SIZE];
   int          good_plen;

   rsp_type pending_rsp [$];
   int      mismatches;
   int      sent_items;
   int      burst_left;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("[escaped_cobs_crc_frame_receiver] ERROR");
      $finish;
   end

   function automatic logic [31:0] crc_of(int len);
      logic [31:0] c;
      c = 32'hFFFFFFFF;
      for (int i = 0; i < len; i++) begin
         c ^= {24'd0, frame_bytes[i]};
         for (int b = 0; b < 8; b++) c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
      end
      return ~c;
   endfunction

   // Undo COBS stuffing into frame_bytes; -1 on a malformed block
   function automatic int unstuff_raw();
      int rd, wr, code;
      rd = 0;
      wr = 0;
      while (rd < raw_fill) begin
         code = raw_bytes[rd];
         rd++;
         if (code == 0) return -1;
         if (rd + code - 1 > raw_fill || wr + code - 1 > DEC_SIZE) return -1;
         for (int k = 0; k < code - 1; k++) frame_bytes[wr + k] = raw_bytes[rd + k];
         rd += code - 1;
         wr += code - 1;
         if (code < 255 && rd < raw_fill) begin
            if (wr >= DEC_SIZE) return -1;
            frame_bytes[wr] = 8'd0;
            wr++;
         end
      end
      return wr;
   endfunction

   function automatic logic [31:0] le32(int at);
      return {frame_bytes[at + 3], frame_bytes[at + 2], frame_bytes[at + 1], frame_bytes[at]};
   endfunction

   function automatic rsp_type close_frame();
      rsp_type o;
      int got, plen;
      o = '0;
      o.kind = KIND_REPORT;
      got = unstuff_raw();
      plen = 0;
      if (got < 0) o.status = ST_COBS;
      else if (got < MIN_FRAME) o.status = ST_SHORT;
      else begin
         plen = {frame_bytes[8], frame_bytes[7]};
         if (plen > PAYLOAD_LIMIT || got != HDR_LEN + plen + CRC_LEN) o.status = ST_LENGTH;
         else if (crc_of(HDR_LEN + plen) != le32(HDR_LEN + plen)) o.status = ST_CRC;
      end
      if (o.status == ST_OK) begin
         o.frame_type     = frame_bytes[0];
         o.xfer_id        = frame_bytes[1];
         o.frame_flags    = frame_bytes[2];
         o.sequence_res   = le32(3);
         o.payload_length = plen[8:0];
         good_plen = plen;
      end else begin
         good_plen = 0;
      end
      rx_mode = RX_IDLE;
      raw_fill = 0;
      return o;
   endfunction

   function automatic void keep_byte(logic [7:0] b);
      if (raw_fill >= RAW_SIZE) begin
         rx_mode = RX_IDLE;
         raw_fill = 0;
         return;
      end
      raw_bytes[raw_fill] = b;
      raw_fill++;
      rx_mode = RX_FRAME;
   endfunction

   // Advance the receiver by one request; returns 1 when a result is due
   function automatic bit receive_step(req_type r, output rsp_type o);
      o = '0;
      if (r.func == FUNC_READ) begin
         o.kind = KIND_READ;
         if (int'(r.read_index) < good_plen) o.read_data = frame_bytes[HDR_LEN + r.read_index];
         return 1'b1;
      end
      case (rx_mode)
         RX_IDLE: begin
            if (r.wire_byte == cfg_marker) begin
               raw_fill = 0;
               rx_mode = RX_FRAME;
            end
         end
         RX_FRAME: begin
            if (r.wire_byte == cfg_marker) begin
               if (raw_fill == 0) return 1'b0;
               o = close_frame();
               return 1'b1;
            end
            if (r.wire_byte == cfg_escape) rx_mode = RX_ESC;
            else keep_byte(r.wire_byte);
         end
         default: keep_byte(r.wire_byte ^ cfg_xor);
      endcase
      return 1'b0;
   endfunction

   // Drive one request and hold it until accepted; a typed expectation may override
   task automatic send_req(req_type r, bit typed = 1'b0, rsp_type typed_rsp = '0);
      rsp_type o;
      bit has;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      has = receive_step(r, o);
      if (has) begin
         pending_rsp.push_back(typed ? typed_rsp : o);
      end
      sent_items++;
   endtask

   task automatic push_byte(logic [7:0] b);
      req_type r;
      r = '0;
      r.func = FUNC_PUSH;
      r.wire_byte = b;
      r.read_index = 8'($urandom);
      send_req(r);
   endtask

   task automatic read_byte(logic [7:0] idx);
      req_type r;
      r.func = FUNC_READ;
      r.wire_byte = 8'($urandom);
      r.read_index = idx;
      send_req(r);
   endtask

   // Pause until every expected result has come, then let the block settle
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [7:0] val);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_MARKER: cfg_marker = val;
         CSR_ESCAPE: cfg_escape = val;
         CSR_XOR:    cfg_xor = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Build, stuff, escape and send one frame with the given payload size and damage
   task automatic drive_frame(int plen, damage_type dmg);
      logic [7:0] dec [$];
      logic [7:0] raw [$];
      logic [31:0] c;
      int len_field, code_at, run;
      dec.push_back(8'($urandom));
      dec.push_back(8'($urandom));
      dec.push_back(8'($urandom));
      repeat (4) dec.push_back(($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom));
      len_field = (dmg == DMG_LEN_FIELD) ? plen + $urandom_range(1, 3) : plen;
      dec.push_back(len_field[7:0]);
      dec.push_back(len_field[15:8]);
      repeat (plen) dec.push_back(($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom));
      c = 32'hFFFFFFFF;
      foreach (dec[i]) begin
         c ^= {24'd0, dec[i]};
         for (int b = 0; b < 8; b++) c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
      end
      c = ~c;
      for (int i = 0; i < 4; i++) dec.push_back(c[8*i +: 8]);
      if (dmg == DMG_CRC) dec[$urandom_range(0, dec.size() - 1)] ^= 8'(1 << $urandom_range(0, 7));
      if (dmg == DMG_TRUNC) repeat ($urandom_range(1, dec.size() - 1)) void'(dec.pop_back());
      // COBS stuffing
      code_at = 0;
      run = 0;
      raw.push_back(8'd0);
      foreach (dec[i]) begin
         if (dec[i] == 8'd0) begin
            raw[code_at] = 8'(run + 1);
            code_at = raw.size();
            raw.push_back(8'd0);
            run = 0;
         end else begin
            raw.push_back(dec[i]);
            run++;
            if (run == 254) begin
               raw[code_at] = COBS_LONG;
               code_at = raw.size();
               raw.push_back(8'd0);
               run = 0;
            end
         end
      end
      raw[code_at] = 8'(run + 1);
      if (dmg == DMG_ZERO_CODE) raw.insert($urandom_range(0, raw.size() - 1), 8'd0);
      if (dmg == DMG_OVERRUN) raw[code_at] = 8'(run + 2 + $urandom_range(0, 5));
      // Escape and send between markers
      push_byte(cfg_marker);
      foreach (raw[i]) begin
         if (raw[i] == cfg_marker || raw[i] == cfg_escape) begin
            push_byte(cfg_escape);
            push_byte(raw[i] ^ cfg_xor);
         end else begin
            push_byte(raw[i]);
         end
      end
      push_byte(cfg_marker);
   endtask

   task automatic random_phase(int items);
      int stop_at, pick;
      stop_at = sent_items + items;
      while (sent_items < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            pick = $urandom_range(0, 9);
            drive_frame(($urandom_range(0, 30) == 0) ? PAYLOAD_LIMIT : $urandom_range(0, 20),
                        damage_type'((pick < 5) ? 0 : pick - 4));
         end else if (pick < 85) begin
            read_byte((good_plen > 0 && $urandom_range(0, 3) != 0) ?
                      8'($urandom_range(0, good_plen - 1)) : 8'($urandom));
         end else begin
            push_byte(8'($urandom));
         end
      end
   endtask

   // Check results in order against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", rsp_payload);
         end else begin
            if (rsp_payload !== pending_rsp[0]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result mismatch: expected %p, got %p", pending_rsp[0], rsp_payload);
            end
            void'(pending_rsp.pop_front());
         end
      end
   end

   // Receiver stall pattern: long ready stretches, then choppy ones
   always @(posedge clock) begin
      if ((($time / 10) / 300) % 3 == 0) rsp_ready <= 1'b1;
      else rsp_ready <= ($urandom_range(0, 2) != 0);
   end

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type rsp;
   } row_type;

   row_type rows [$];

   function automatic row_type make_row(logic func, logic [7:0] b, logic [7:0] idx,
                                         bit typed = 1'b0, logic kind = KIND_READ,
                                         logic [2:0] status = ST_OK);
      row_type r;
      r.req = '{func: func, wire_byte: b, read_index: idx};
      r.typed = typed;
      r.rsp = '0;
      r.rsp.kind = kind;
      r.rsp.status = status;
      return r;
   endfunction

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = CSR_MARKER;
      csr_write_data = '0;
      mismatches = 0;
      sent_items = 0;
      burst_left = 4;
      cfg_marker = MARKER_RESET;
      cfg_escape = ESCAPE_RESET;
      cfg_xor = XOR_RESET;
      rx_mode = RX_IDLE;
      raw_fill = 0;
      good_plen = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table: reads after reset, idle noise, empty and malformed frames
      rows.push_back(make_row(FUNC_READ, 8'h00, 8'h00, 1'b1));
      rows.push_back(make_row(FUNC_READ, 8'hFF, 8'hFF, 1'b1));
      rows.push_back(make_row(FUNC_PUSH, 8'h00, 8'h00));
      rows.push_back(make_row(FUNC_PUSH, 8'hFF, 8'hFF));
      rows.push_back(make_row(FUNC_PUSH, MARKER_RESET, 8'h00));
      rows.push_back(make_row(FUNC_PUSH, MARKER_RESET, 8'h00));
      rows.push_back(make_row(FUNC_PUSH, 8'h00, 8'h00));
      rows.push_back(make_row(FUNC_PUSH, MARKER_RESET, 8'h00, 1'b1, KIND_REPORT, ST_COBS));
      rows.push_back(make_row(FUNC_PUSH, MARKER_RESET, 8'h00));
      rows.push_back(make_row(FUNC_PUSH, 8'h02, 8'h00));
      rows.push_back(make_row(FUNC_PUSH, 8'h11, 8'h00));
      rows.push_back(make_row(FUNC_PUSH, MARKER_RESET, 8'h00, 1'b1, KIND_REPORT, ST_SHORT));
      // Marker after escape is data
      rows.push_back(make_row(FUNC_PUSH, MARKER_RESET, 8'h00));
      rows.push_back(make_row(FUNC_PUSH, 8'h02, 8'h00));
      rows.push_back(make_row(FUNC_PUSH, ESCAPE_RESET, 8'h00));
      rows.push_back(make_row(FUNC_PUSH, MARKER_RESET, 8'h00));
      rows.push_back(make_row(FUNC_PUSH, MARKER_RESET, 8'h00, 1'b1, KIND_REPORT, ST_SHORT));
      rows.push_back(make_row(FUNC_READ, 8'h00, 8'h80, 1'b1));
      foreach (rows[i]) send_req(rows[i].req, rows[i].typed, rows[i].rsp);

      // Good frames at the payload extremes, reads of them, then an oversized frame and a read after it
      drive_frame(0, DMG_NONE);
      drive_frame(PAYLOAD_LIMIT, DMG_NONE);
      read_byte(8'd0);
      read_byte(8'd255);
      drive_frame(PAYLOAD_LIMIT + 1, DMG_NONE);
      read_byte(8'd1);

      // Overflow the raw store, then recover
      push_byte(cfg_marker);
      repeat (RAW_SIZE + 3) push_byte(8'h5A);
      drive_frame(3, DMG_NONE);
      random_phase(60);
      drain();

      write_csr(CSR_MARKER, 8'h00);
      write_csr(CSR_ESCAPE, 8'hFF);
      write_csr(CSR_XOR, 8'hFF);
      write_csr(2'd3, 8'hAA);
      random_phase(60);
      drain();

      write_csr(CSR_MARKER, 8'hFF);
      write_csr(CSR_ESCAPE, 8'h00);
      write_csr(CSR_XOR, 8'h00);
      random_phase(60);
      drain();

      write_csr(CSR_MARKER, 8'h01);
      write_csr(CSR_ESCAPE, 8'h02);
      write_csr(CSR_XOR, 8'h80);
      random_phase(60);
      drain();

      if (mismatches == 0 && pending_rsp.size() == 0)
         $display("[escaped_cobs_crc_frame_receiver] OK");
      else
         $display("[escaped_cobs_crc_frame_receiver] ERROR");
      $finish;
   end

endmodule
